@@ src/rpnp_pkg.sv @@
// rpnp_pkg: shared types and constants of the radix-prefixed number parser
// no dependencies; used by rpnp_char_decode and radix_prefixed_number_parser
`timescale 1ns / 1ps
`default_nettype none
package rpnp_pkg;

   // token parse phase; the fourth code is never entered and acts like digits
   typedef enum logic [1:0] {
      PH_START  = 2'd0,
      PH_BASE   = 2'd1,
      PH_DIGITS = 2'd2
   } phase_type;

   // error codes
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_BASE  = 2'd1;
   localparam logic [1:0] ERR_DIGIT = 2'd2;
   localparam logic [1:0] ERR_OVER  = 2'd3;

   // radix codes
   localparam logic [1:0] RADIX_BIN = 2'd0;
   localparam logic [1:0] RADIX_OCT = 2'd1;
   localparam logic [1:0] RADIX_DEC = 2'd2;
   localparam logic [1:0] RADIX_HEX = 2'd3;

   // ascii codes
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_BASE_B  = 8'h62;
   localparam logic [7:0] CHAR_BASE_O  = 8'h6F;
   localparam logic [7:0] CHAR_BASE_D  = 8'h64;
   localparam logic [7:0] CHAR_BASE_X  = 8'h78;

   localparam logic [7:0] DIGIT_TEN = 8'd10;

   // decoded view of one character
   typedef struct packed {
      logic       base_ok;
      logic [1:0] base_code;
      logic       digit_ok;
      logic [3:0] digit;
   } decode_type;

endpackage
`default_nettype wire

@@ src/radix_prefixed_number_parser.sv @@
// radix_prefixed_number_parser: top level of the ascii number token parser
// depends on rpnp_pkg and rpnp_char_decode
`timescale 1ns / 1ps
`default_nettype none
// A token arrives one ascii character per transfer on the req_ channel, with
// req_last_char set on its final character: an optional '-', a lower-case base
// letter (b, o, d, x), then digits (hex digits in either case). Each character
// is captured in an input register and from there folded into the running
// magnitude by one shift-and-add step (times 2, 8, 10 or 16 plus the digit)
// with an overflow check on the same sum. The block takes one character per
// cycle back to back; the last character passes from the input register into
// the result register, whose valid flag drives rsp_valid. The input keeps
// flowing while a result waits, stalling only when a second last character
// finds the result register still full. The result carries the signed value
// (0 on any error), the base seen and an error code: 1 bad base letter, 2 bad
// digit, 3 magnitude above the largest positive value of VALUE_BITS bits.
// After each result the parser is back at the start of a token.
module radix_prefixed_number_parser #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,

   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic [7:0]                   req_char_code,
   input  wire logic                         req_last_char,

   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic signed [VALUE_BITS-1:0] rsp_value,
   output      logic [1:0]                   rsp_radix_kind,
   output      logic [1:0]                   rsp_error_code
);

   localparam int MAG_W  = VALUE_BITS - 1;   // magnitude never exceeds max positive
   localparam int PROD_W = VALUE_BITS + 3;   // room for magnitude * 16 + 15

   // input register
   logic       stage_valid_ff, stage_valid_in;
   logic [7:0] stage_char_ff;
   logic       stage_last_ff;

   // token state
   rpnp_pkg::phase_type phase_ff, phase_in;
   logic                neg_ff, neg_in;
   logic [1:0]          radix_ff, radix_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic [1:0]          err_ff, err_in;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]            rsp_radix_ff, rsp_radix_in;
   logic [1:0]            rsp_error_ff, rsp_error_in;

   logic out_free;
   logic stage_go;
   logic take_req;

   rpnp_pkg::decode_type info;

   logic [PROD_W-1:0]     mag_ext;
   logic [PROD_W-1:0]     prod;
   logic [VALUE_BITS-1:0] mag_val;

   // one shared decoder for the staged character
   rpnp_char_decode u_decode (
      .char_code  (stage_char_ff),
      .radix_code (radix_ff),
      .info       (info)
   );

   // handshake: a staged character moves on unless it ends a token and the
   // result register is still occupied
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign stage_go  = stage_valid_ff && (!stage_last_ff || out_free);
   assign req_ready = !stage_valid_ff || stage_go;
   assign take_req  = req_valid && req_ready;

   assign stage_valid_in = take_req || (stage_valid_ff && !stage_go);

   // accumulate step: magnitude * base + digit
   assign mag_ext = {{(PROD_W-MAG_W){1'b0}}, mag_ff};

   always_comb begin
      unique case (radix_ff)
         rpnp_pkg::RADIX_BIN: prod = (mag_ext << 1);
         rpnp_pkg::RADIX_OCT: prod = (mag_ext << 3);
         rpnp_pkg::RADIX_DEC: prod = (mag_ext << 3) + (mag_ext << 1);
         default:             prod = (mag_ext << 4);
      endcase
      prod = prod + {{(PROD_W-4){1'b0}}, info.digit};
   end

   // next token state and result
   always_comb begin
      phase_in     = phase_ff;
      neg_in       = neg_ff;
      radix_in     = radix_ff;
      mag_in       = mag_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_radix_in = rsp_radix_ff;
      rsp_error_in = rsp_error_ff;
      mag_val      = '0;

      if (stage_go) begin
         unique case (phase_ff)
            rpnp_pkg::PH_START,
            rpnp_pkg::PH_BASE: begin
               if (phase_ff == rpnp_pkg::PH_START && stage_char_ff == rpnp_pkg::CHAR_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = rpnp_pkg::PH_BASE;
               end else begin
                  if (info.base_ok) begin
                     radix_in = info.base_code;
                  end else begin
                     err_in   = rpnp_pkg::ERR_BASE;
                     radix_in = rpnp_pkg::RADIX_BIN;
                  end
                  phase_in = rpnp_pkg::PH_DIGITS;
               end
            end
            default: begin
               // after a bad base the rest of the token is ignored
               if (err_ff != rpnp_pkg::ERR_BASE) begin
                  if (!info.digit_ok) begin
                     err_in = rpnp_pkg::ERR_DIGIT;
                  end else if (err_ff == rpnp_pkg::ERR_NONE) begin
                     if (prod[PROD_W-1:MAG_W] != '0) begin
                        err_in = rpnp_pkg::ERR_OVER;
                     end else begin
                        mag_in = prod[MAG_W-1:0];
                     end
                  end
               end
            end
         endcase

         if (stage_last_ff) begin
            // token ended before its base letter
            if (phase_in != rpnp_pkg::PH_DIGITS) begin
               err_in   = rpnp_pkg::ERR_BASE;
               radix_in = rpnp_pkg::RADIX_BIN;
            end
            mag_val = {1'b0, mag_in};
            rsp_valid_in = 1'b1;
            rsp_radix_in = radix_in;
            rsp_error_in = err_in;
            if (err_in != rpnp_pkg::ERR_NONE) begin
               rsp_value_in = '0;
            end else if (neg_in) begin
               rsp_value_in = '0 - mag_val;
            end else begin
               rsp_value_in = mag_val;
            end
            // back to the start of a token
            phase_in = rpnp_pkg::PH_START;
            neg_in   = 1'b0;
            radix_in = rpnp_pkg::RADIX_BIN;
            mag_in   = '0;
            err_in   = rpnp_pkg::ERR_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         phase_ff       <= rpnp_pkg::PH_START;
         neg_ff         <= 1'b0;
         radix_ff       <= rpnp_pkg::RADIX_BIN;
         mag_ff         <= '0;
         err_ff         <= rpnp_pkg::ERR_NONE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         phase_ff       <= phase_in;
         neg_ff         <= neg_in;
         radix_ff       <= radix_in;
         mag_ff         <= mag_in;
         err_ff         <= err_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (take_req) begin
         stage_char_ff <= req_char_code;
         stage_last_ff <= req_last_char;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_radix_ff <= rsp_radix_in;
      rsp_error_ff <= rsp_error_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = rsp_value_ff;
   assign rsp_radix_kind = rsp_radix_ff;
   assign rsp_error_code = rsp_error_ff;

endmodule
`default_nettype wire

@@ src/rpnp_char_decode.sv @@
// rpnp_char_decode: classifies one ascii character as base letter and as digit
// depends on rpnp_pkg
`timescale 1ns / 1ps
`default_nettype none
module rpnp_char_decode (
   input  wire logic [7:0]         char_code,
   input  wire logic [1:0]         radix_code,
   output rpnp_pkg::decode_type    info
);

   logic [7:0] raw;
   logic       is_digit;

   always_comb begin
      raw      = 8'd0;
      is_digit = 1'b0;
      info     = '0;

      priority if (char_code >= rpnp_pkg::CHAR_ZERO && char_code <= rpnp_pkg::CHAR_NINE) begin
         raw      = char_code - rpnp_pkg::CHAR_ZERO;
         is_digit = 1'b1;
      end else if (char_code >= rpnp_pkg::CHAR_LOWER_A
                   && char_code <= rpnp_pkg::CHAR_LOWER_F) begin
         raw      = char_code - rpnp_pkg::CHAR_LOWER_A + rpnp_pkg::DIGIT_TEN;
         is_digit = 1'b1;
      end else if (char_code >= rpnp_pkg::CHAR_UPPER_A
                   && char_code <= rpnp_pkg::CHAR_UPPER_F) begin
         raw      = char_code - rpnp_pkg::CHAR_UPPER_A + rpnp_pkg::DIGIT_TEN;
         is_digit = 1'b1;
      end else begin
         raw      = 8'd0;
         is_digit = 1'b0;
      end

      info.digit = raw[3:0];

      // digit must lie below the base
      unique case (radix_code)
         rpnp_pkg::RADIX_BIN: info.digit_ok = is_digit && (raw[3:0] < 4'd2);
         rpnp_pkg::RADIX_OCT: info.digit_ok = is_digit && (raw[3:0] < 4'd8);
         rpnp_pkg::RADIX_DEC: info.digit_ok = is_digit && (raw[3:0] < 4'd10);
         default:             info.digit_ok = is_digit;
      endcase

      unique case (char_code)
         rpnp_pkg::CHAR_BASE_B: begin
            info.base_ok   = 1'b1;
            info.base_code = rpnp_pkg::RADIX_BIN;
         end
         rpnp_pkg::CHAR_BASE_O: begin
            info.base_ok   = 1'b1;
            info.base_code = rpnp_pkg::RADIX_OCT;
         end
         rpnp_pkg::CHAR_BASE_D: begin
            info.base_ok   = 1'b1;
            info.base_code = rpnp_pkg::RADIX_DEC;
         end
         rpnp_pkg::CHAR_BASE_X: begin
            info.base_ok   = 1'b1;
            info.base_code = rpnp_pkg::RADIX_HEX;
         end
         default: begin
            info.base_ok   = 1'b0;
            info.base_code = rpnp_pkg::RADIX_BIN;
         end
      endcase
   end

endmodule
`default_nettype wire
